// File: design/fsts_pkg.sv
package fsts_pkg;

   // scaling: one step divides by 1024 while the value is above the limit
   localparam logic [63:0] LIMIT_VALUE = 64'd9999;
   localparam int unsigned SCALE_SHIFT = 10;
   localparam int unsigned NUM_CELLS   = 6;
   localparam int unsigned LEVEL_W     = 3;
   localparam int unsigned FRAC_W      = 10;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL = 3'd5;

   // decimal conversion of the scaled value (never above 9999)
   localparam int unsigned SCALED_W  = 14;
   localparam int unsigned NUM_DIGITS = 4;
   localparam logic [12:0] RECIP_TEN = 13'd6554;   // 2^16 / 10, rounded up

   localparam logic [6:0] ASCII_SPACE = 7'h20;
   localparam logic [6:0] ASCII_DOT   = 7'h2e;
   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_B     = 7'h62;
   localparam logic [6:0] ASCII_K     = 7'h6b;
   localparam logic [6:0] ASCII_M     = 7'h6d;
   localparam logic [6:0] ASCII_G     = 7'h67;
   localparam logic [6:0] ASCII_T     = 7'h74;
   localparam logic [6:0] ASCII_QUERY = 7'h3f;

   // data moving along the row of scaling cells
   typedef struct packed {
      logic               valid;
      logic [63:0]        value;
      logic [LEVEL_W-1:0] level;
      logic [FRAC_W-1:0]  frac;
   } cell_data_type;

   // finished text handed to the result ports
   typedef struct packed {
      logic            valid;
      logic [4:0][6:0] chars;
   } text_type;

   function automatic logic [6:0] suffix_char(input logic [LEVEL_W-1:0] level);
      logic [6:0] c;
      unique case (level)
         3'd0:    c = ASCII_B;
         3'd1:    c = ASCII_K;
         3'd2:    c = ASCII_M;
         3'd3:    c = ASCII_G;
         3'd4:    c = ASCII_T;
         default: c = ASCII_QUERY;
      endcase
      return c;
   endfunction

endpackage

// File: design/fsts_cell.sv
module fsts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  fsts_pkg::cell_data_type prev,
   output fsts_pkg::cell_data_type next
);

   fsts_pkg::cell_data_type next_ff, next_in;

   // one scaling step when the value is above the limit: shift out ten bits and keep them for the tenths digit
   always_comb begin
      next_in = prev;
      if (prev.value > fsts_pkg::LIMIT_VALUE) begin
         next_in.value = prev.value >> fsts_pkg::SCALE_SHIFT;
         next_in.level = prev.level + 3'd1;
         next_in.frac  = prev.value[fsts_pkg::FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      next_ff.value <= next_in.value;
      next_ff.level <= next_in.level;
      next_ff.frac  <= next_in.frac;
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else begin
         next_ff.valid <= next_in.valid;
      end
   end

   assign next = next_ff;

endmodule

// File: design/fsts_digits.sv
module fsts_digits (
   input  logic                    clock,
   input  logic                    reset,
   input  fsts_pkg::cell_data_type scaled,
   output fsts_pkg::text_type      text
);

   logic                              active_ff, active_in;
   logic [1:0]                        step_ff, step_in;
   logic [fsts_pkg::SCALED_W-1:0]     n_ff, n_in;
   logic [3:0][6:0]                   chars_ff, chars_in;
   logic [fsts_pkg::LEVEL_W-1:0]      level_ff, level_in;
   logic [3:0]                        tenths_ff, tenths_in;
   logic                              two_digit_ff, two_digit_in;
   fsts_pkg::text_type                text_ff, text_in;

   logic [26:0] prod;
   logic [9:0]  quot;
   logic [13:0] quot_ten;
   logic [3:0]  rem;
   logic [6:0]  digit_char;
   logic [13:0] frac_ten;

   always_comb begin
      // divide by ten through the reciprocal, exact below 10000
      prod       = 27'(n_ff) * 27'(fsts_pkg::RECIP_TEN);
      quot       = prod[25:16];
      quot_ten   = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
      rem        = 4'(n_ff - quot_ten);
      digit_char = ((step_ff != 2'd0) && (n_ff == '0)) ? fsts_pkg::ASCII_SPACE
                                                      : fsts_pkg::ASCII_ZERO + 7'(rem);
      frac_ten   = {1'b0, scaled.frac, 3'b000} + {3'b000, scaled.frac, 1'b0};

      active_in    = active_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      chars_in     = chars_ff;
      level_in     = level_ff;
      tenths_in    = tenths_ff;
      two_digit_in = two_digit_ff;
      text_in      = text_ff;
      text_in.valid = 1'b0;

      if (active_ff) begin
         chars_in = {digit_char, chars_ff[3:1]};
         n_in     = 14'(quot);
         step_in  = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            active_in     = 1'b0;
            text_in.valid = 1'b1;
            // chars_in[3] is the leftmost digit, chars_in[0] the units
            if (two_digit_ff) begin
               text_in.chars[0] = chars_in[1];
               text_in.chars[1] = chars_in[0];
               text_in.chars[2] = fsts_pkg::ASCII_DOT;
               text_in.chars[3] = fsts_pkg::ASCII_ZERO + 7'(tenths_ff);
            end else begin
               text_in.chars[0] = chars_in[3];
               text_in.chars[1] = chars_in[2];
               text_in.chars[2] = chars_in[1];
               text_in.chars[3] = chars_in[0];
            end
            text_in.chars[4] = fsts_pkg::suffix_char(
               (level_ff > fsts_pkg::MAX_LEVEL) ? fsts_pkg::MAX_LEVEL : level_ff);
         end
      end else if (scaled.valid) begin
         active_in    = 1'b1;
         step_in      = 2'd0;
         n_in         = scaled.value[fsts_pkg::SCALED_W-1:0];
         level_in     = scaled.level;
         tenths_in    = frac_ten[13:10];
         two_digit_in = (scaled.value < 64'd100) && (scaled.level != '0);
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      n_ff          <= n_in;
      chars_ff      <= chars_in;
      level_ff      <= level_in;
      tenths_ff     <= tenths_in;
      two_digit_ff  <= two_digit_in;
      text_ff.chars <= text_in.chars;
      if (reset) begin
         active_ff     <= 1'b0;
         text_ff.valid <= 1'b0;
      end else begin
         active_ff     <= active_in;
         text_ff.valid <= text_in.valid;
      end
   end

   assign text = text_ff;

endmodule

// File: design/file_size_to_five_char_text.sv
// five-character file size text: byte count in, "1234k" or "12.3m" style text out
//
// input: pulse start with req_byte_count while busy is low; that cycle's edge
//    takes the transfer and busy rises on the next cycle
// output: rsp_valid is high for exactly one cycle with rsp_char_0..rsp_char_4;
//    the receiver takes the transfer at the end of that cycle and cannot stall
// flow: busy drops with the edge that takes the result transfer, so the
//    block takes no new item until the last one is through; an item passes
//    the row of six scaling cells (at most one divide by 1024 each, one
//    register each), is loaded into the digit unit, and the digit unit peels
//    one decimal digit per cycle with a reciprocal multiply, four digits in all
// magnitude level 5 and above shows '?'; values below 100 at levels above 0
//    show two digits, a dot and a tenths digit
// reset: synchronous, clears busy and all valid flags; no item survives it
module file_size_to_five_char_text (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_byte_count,
   output logic        rsp_valid,
   output logic [6:0]  rsp_char_0,
   output logic [6:0]  rsp_char_1,
   output logic [6:0]  rsp_char_2,
   output logic [6:0]  rsp_char_3,
   output logic [6:0]  rsp_char_4
);

   logic busy_ff, busy_in;
   logic accept;

   // one link per cell boundary, link 0 fed from the request port
   fsts_pkg::cell_data_type links [fsts_pkg::NUM_CELLS+1];
   fsts_pkg::text_type      text;

   assign accept = start && !busy_ff;

   // head of the chain: fresh count at level zero
   assign links[0] = {accept, req_byte_count, {fsts_pkg::LEVEL_W{1'b0}},
                      {fsts_pkg::FRAC_W{1'b0}}};

   // row of scaling cells, each hands its result to the next every cycle
   for (genvar i = 0; i < fsts_pkg::NUM_CELLS; i++) begin : g_cell
      fsts_cell u_cell (
         .clock (clock),
         .reset (reset),
         .prev  (links[i]),
         .next  (links[i+1])
      );
   end

   // decimal digits and final layout
   fsts_digits u_digits (
      .clock  (clock),
      .reset  (reset),
      .scaled (links[fsts_pkg::NUM_CELLS]),
      .text   (text)
   );

   // busy from the accepting edge through the result cycle
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (text.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = text.valid;
   assign rsp_char_0 = text.chars[0];
   assign rsp_char_1 = text.chars[1];
   assign rsp_char_2 = text.chars[2];
   assign rsp_char_3 = text.chars[3];
   assign rsp_char_4 = text.chars[4];

   // a result only ever belongs to an accepted item
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy_ff)
      else $error("result transfer without an item in flight");

   // an accepted item makes the block busy
   assert property (@(posedge clock) disable iff (reset) accept |=> busy_ff)
      else $error("busy not raised after accept");

   // no two results back to back
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the block frees itself right after the result
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy_ff)
      else $error("busy still high after result");

endmodule

// File: tb/tb_file_size_to_five_char_text.sv
module tb_file_size_to_five_char_text;
   timeunit 1ns;
   timeprecision 1ps;

   // five characters of text, index 0 is the leftmost one
   typedef logic [4:0][6:0] size_text_type;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned DRAIN_CYCLES  = 24;
   localparam int unsigned RANDOM_PER_PH = 220;
   localparam int unsigned NUM_PHASES    = 4;
   localparam int unsigned NUM_CORNERS   = 22;

   // sender idle percentage per phase: none, heavy, none (the receiver
   // cannot stall, so its phase runs clean), light
   localparam int unsigned PHASE_IDLE_PCT [NUM_PHASES] = '{0, 46, 0, 6};

   // corner counts: zero, digit roll-overs, the boundaries into levels 1 and 2,
   // the tenths form at both ends, the first count needing six shifts, all ones
   localparam logic [63:0] CORNER_COUNTS [NUM_CORNERS] = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd9999, 64'd10000,
      64'd10239, 64'd10240, 64'd11263, 64'd102399, 64'd102400, 64'd10239999,
      64'd10240000, 64'd1 << 40, (64'd10000 << 50) - 64'd1, 64'd10000 << 50,
      64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_byte_count = '0;
   logic        rsp_valid;
   logic [6:0]  rsp_char_0;
   logic [6:0]  rsp_char_1;
   logic [6:0]  rsp_char_2;
   logic [6:0]  rsp_char_3;
   logic [6:0]  rsp_char_4;

   logic [63:0]    byte_count_q[$];     // counts waiting to be sent
   size_text_type  size_text_q[$];      // text expected back, oldest first
   int unsigned    sender_idle_pct = 0;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;

   file_size_to_five_char_text u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_byte_count (req_byte_count),
      .rsp_valid      (rsp_valid),
      .rsp_char_0     (rsp_char_0),
      .rsp_char_1     (rsp_char_1),
      .rsp_char_2     (rsp_char_2),
      .rsp_char_3     (rsp_char_3),
      .rsp_char_4     (rsp_char_4)
   );

   always #6 clock = ~clock;

   // text the block should print for a count
   function automatic size_text_type format_size_text(input logic [63:0] count);
      logic [63:0]   value;
      logic [63:0]   last_unshifted;
      int unsigned   level;
      int unsigned   n;
      int unsigned   tenths;
      size_text_type txt;
      value = count;
      last_unshifted = count;
      level = 0;
      // scale down by 1024 until four digits are enough
      while (value > fsts_pkg::LIMIT_VALUE) begin
         level++;
         last_unshifted = value;
         value = value >> fsts_pkg::SCALE_SHIFT;
      end
      n = int'(value[13:0]);
      txt = {5{fsts_pkg::ASCII_SPACE}};
      if (n < 100 && level > 0) begin
         // two digits, dot, tenths taken from the bits dropped by the last shift
         tenths = int'(last_unshifted[9:0]) * 10 / 1024;
         txt[1] = fsts_pkg::ASCII_ZERO + 7'(n % 10);
         if (n >= 10) begin
            txt[0] = fsts_pkg::ASCII_ZERO + 7'(n / 10);
         end
         txt[2] = fsts_pkg::ASCII_DOT;
         txt[3] = fsts_pkg::ASCII_ZERO + 7'(tenths);
      end else begin
         // four digits, right-justified, leading zeros blanked but the last kept
         for (int i = 3; i >= 0; i--) begin
            if (i == 3 || n != 0) begin
               txt[i] = fsts_pkg::ASCII_ZERO + 7'(n % 10);
               n = n / 10;
            end
         end
      end
      case (level)
         0:       txt[4] = fsts_pkg::ASCII_B;
         1:       txt[4] = fsts_pkg::ASCII_K;
         2:       txt[4] = fsts_pkg::ASCII_M;
         3:       txt[4] = fsts_pkg::ASCII_G;
         4:       txt[4] = fsts_pkg::ASCII_T;
         default: txt[4] = fsts_pkg::ASCII_QUERY;   // level 5 and the six-shift case
      endcase
      return txt;
   endfunction

   // random count, partly steered at level boundaries and the tenths form
   function automatic logic [63:0] random_byte_count();
      logic [63:0] raw;
      logic [63:0] low_mask;
      int unsigned level;
      int unsigned pick;
      raw = {$urandom(), $urandom()};
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         // any magnitude, from tiny to huge
         return raw >> $urandom_range(0, 63);
      end else if (pick < 6) begin
         return raw;
      end else if (pick < 8) begin
         // scaled value close to the four-digit limit
         level = $urandom_range(0, 5);
         low_mask = (64'd1 << (10 * level)) - 64'd1;
         return (64'($urandom_range(9990, 10010)) << (10 * level)) | (raw & low_mask);
      end else begin
         // scaled value in the tenths range
         level = $urandom_range(1, 5);
         low_mask = (64'd1 << (10 * level)) - 64'd1;
         return (64'($urandom_range(9, 101)) << (10 * level)) | (raw & low_mask);
      end
   endfunction

   // driver: offers the oldest waiting count on start, idling at random, until a
   // transfer happens (start high, busy low at the edge)
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            size_text_q.push_back(format_size_text(req_byte_count));
            void'(byte_count_q.pop_front());
         end
         // one assignment to start per edge keeps back-to-back items clean
         if (byte_count_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            start          <= 1'b1;
            req_byte_count <= byte_count_q[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is one result transfer, checked against the oldest
   always @(posedge clock) begin
      size_text_type got;
      size_text_type want;
      got = {rsp_char_4, rsp_char_3, rsp_char_2, rsp_char_1, rsp_char_0};
      if (!reset && rsp_valid) begin
         if (size_text_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual \"%s\"", $realtime,
                     {1'b0, got[0], 1'b0, got[1], 1'b0, got[2], 1'b0, got[3],
                      1'b0, got[4]});
         end else begin
            want = size_text_q.pop_front();
            for (int k = 0; k < 5; k++) begin
               if (got[k] !== want[k]) begin
                  error_count++;
                  $display("%0t: rsp_char_%0d mismatch, expected 0x%02h, actual 0x%02h",
                           $realtime, k, want[k], got[k]);
               end
            end
         end
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // stimulus sequence and end of run
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // queue is refilled away from the active edge
         @(negedge clock);
         sender_idle_pct = PHASE_IDLE_PCT[ph];
         if (ph == 0) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
               byte_count_q.push_back(CORNER_COUNTS[i]);
            end
         end
         for (int i = 0; i < RANDOM_PER_PH; i++) begin
            byte_count_q.push_back(random_byte_count());
         end
         // sender pauses here until every transfer is sent and answered
         while (byte_count_q.size() != 0 || size_text_q.size() != 0) begin
            @(posedge clock);
         end
      end
      // let any stray strobe show up before judging
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && size_text_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
